// File: rtl/uft_pkg.sv
// Package with the opcodes, field widths and entry layout constants of the union-find table.
package uft_pkg;

   // Request opcodes.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_UNION = 2'd2;

   // Width of the element index fields on the ports.
   localparam int ELEM_W = 10;

   // Width wide enough to hold any element index and the table depth itself.
   localparam int EXT_W = 17;

   // Rank field of a table entry and its saturation value.
   localparam int RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

   typedef logic [1:0] opcode_type;

endpackage

// File: rtl/uft_ram.sv
// Single-port-write, single-port-read table memory with registered read data.
module uft_ram #(
   parameter int ADDR_W = 10,
   parameter int DATA_W = 15,
   parameter int DEPTH  = 1024
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/union_find_table_core.sv
// Top level of the union-find table: request sequencer, shared link compare and table memory.
//
// Usage: a request beat (req_opcode, req_elem_a, req_elem_b) is taken at a rising edge where
// start is high and busy is low. Add enters an absent element as its own root; find returns
// the root of elem_a and compresses the path to it; union finds both roots, links them by
// rank and reports the surviving root and whether a merge took place.
// Every request gives exactly one response beat: rsp_strobe is high for one cycle with
// rsp_root and rsp_merged valid in that cycle. The receiver cannot stall the block.
// Each entry access goes through the table memory, whose read data is registered, so every
// entry visited is read once on the walk up and once more on compression. Add reads only
// its own entry, and a find of an absent element or of a root skips compression. A union
// runs its two finds back to back without their response beats, then links the roots by
// rank and, on a rank tie, raises the first root's rank in a further step.
// Out-of-range indices and the unused opcode respond on the cycle after accept.
// busy stays high from accept of an in-range request until its response beat, so a new
// request is taken only once the last is through, as the walk uses the single memory port.
// Reset: synchronous, active high. After reset a clearing pass writes every table entry,
// one per cycle, with busy held high.
module union_find_table_core
   import uft_pkg::*;
#(
   parameter int NUM_RECORDS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [ELEM_W-1:0] req_elem_a,
   input  logic [ELEM_W-1:0] req_elem_b,
   output logic              rsp_strobe,
   output logic [ELEM_W-1:0] rsp_root,
   output logic              rsp_merged
);

   localparam int IW     = $clog2(NUM_RECORDS);
   localparam int WORD_W = 1 + RANK_W + IW;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CLEAR  = 3'd1;
   localparam logic [2:0] ST_F_RD   = 3'd2;
   localparam logic [2:0] ST_F_CHK  = 3'd3;
   localparam logic [2:0] ST_C_RD   = 3'd4;
   localparam logic [2:0] ST_C_CHK  = 3'd5;
   localparam logic [2:0] ST_U_LINK = 3'd6;
   localparam logic [2:0] ST_U_RANK = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [IW-1:0]     clr_ff, clr_in;
   opcode_type        op_ff, op_in;
   logic [IW-1:0]     idx_b_ff, idx_b_in;
   logic [IW-1:0]     cur_ff, cur_in;
   logic [IW-1:0]     target_ff, target_in;
   logic [IW-1:0]     root_ff, root_in;
   logic [RANK_W-1:0] rank_root_ff, rank_root_in;
   logic              phase_b_ff, phase_b_in;
   logic [IW-1:0]     ra_ff, ra_in;
   logic [IW-1:0]     rb_ff, rb_in;
   logic [RANK_W-1:0] rank_a_ff, rank_a_in;
   logic [RANK_W-1:0] rank_b_ff, rank_b_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [ELEM_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_merged_ff, rsp_merged_in;

   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [WORD_W-1:0] rd_data;

   logic              rd_present;
   logic [RANK_W-1:0] rd_rank;
   logic [IW-1:0]     rd_parent;
   logic              link_hit;

   logic              fd_done;
   logic [IW-1:0]     fd_root;
   logic [RANK_W-1:0] fd_rank;

   logic [EXT_W-1:0]  ext_a;
   logic [EXT_W-1:0]  ext_b;
   logic              a_ok;
   logic              b_ok;

   // Widens a table index back to the element field of the ports.
   function automatic logic [ELEM_W-1:0] idx_to_elem(input logic [IW-1:0] idx);
      logic [EXT_W-1:0] ext;
      ext = {{(EXT_W-IW){1'b0}}, idx};
      return ext[ELEM_W-1:0];
   endfunction

   // Table memory: each entry holds {present, rank, parent}.
   uft_ram #(
      .ADDR_W (IW),
      .DATA_W (WORD_W),
      .DEPTH  (NUM_RECORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   // Entry fields and the shared compare that detects a root.
   assign rd_present = rd_data[WORD_W-1];
   assign rd_rank    = rd_data[IW +: RANK_W];
   assign rd_parent  = rd_data[IW-1:0];
   assign link_hit   = (rd_parent == cur_ff);

   // Range checks on the incoming element indices.
   assign ext_a = {{(EXT_W-ELEM_W){1'b0}}, req_elem_a};
   assign ext_b = {{(EXT_W-ELEM_W){1'b0}}, req_elem_b};
   assign a_ok  = (ext_a < EXT_W'(NUM_RECORDS));
   assign b_ok  = (ext_b < EXT_W'(NUM_RECORDS));

   // Sequencer next-state and memory write control.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      idx_b_in      = idx_b_ff;
      cur_in        = cur_ff;
      target_in     = target_ff;
      root_in       = root_ff;
      rank_root_in  = rank_root_ff;
      phase_b_in    = phase_b_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      rank_a_in     = rank_a_ff;
      rank_b_in     = rank_b_ff;
      rsp_strobe_in = 1'b0;
      rsp_root_in   = rsp_root_ff;
      rsp_merged_in = rsp_merged_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      fd_done       = 1'b0;
      fd_root       = cur_ff;
      fd_rank       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_opcode;
               idx_b_in   = ext_b[IW-1:0];
               cur_in     = ext_a[IW-1:0];
               target_in  = ext_a[IW-1:0];
               phase_b_in = 1'b0;
               if (((req_opcode == OP_ADD || req_opcode == OP_FIND) && a_ok) ||
                   (req_opcode == OP_UNION && a_ok && b_ok)) begin
                  state_in = ST_F_RD;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_root_in   = req_elem_a;
                  rsp_merged_in = 1'b0;
               end
            end
         end

         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            if (clr_ff == IW'(NUM_RECORDS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + IW'(1);
            end
         end

         ST_F_RD: begin
            state_in = ST_F_CHK;
         end

         ST_F_CHK: begin
            if (!rd_present) begin
               // Absent element: enter it as its own root with rank zero.
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {1'b1, {RANK_W{1'b0}}, cur_ff};
            end
            if (op_ff == OP_ADD) begin
               rsp_strobe_in = 1'b1;
               rsp_root_in   = idx_to_elem(cur_ff);
               rsp_merged_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (!rd_present) begin
               fd_done = 1'b1;
               fd_root = cur_ff;
               fd_rank = '0;
            end else if (link_hit) begin
               if (cur_ff == target_ff) begin
                  fd_done = 1'b1;
                  fd_root = cur_ff;
                  fd_rank = rd_rank;
               end else begin
                  // Root found: walk the path again from the start to compress it.
                  root_in      = cur_ff;
                  rank_root_in = rd_rank;
                  cur_in       = target_ff;
                  state_in     = ST_C_RD;
               end
            end else begin
               cur_in   = rd_parent;
               state_in = ST_F_RD;
            end
         end

         ST_C_RD: begin
            state_in = ST_C_CHK;
         end

         ST_C_CHK: begin
            if (link_hit) begin
               fd_done = 1'b1;
               fd_root = root_ff;
               fd_rank = rank_root_ff;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = {1'b1, rd_rank, root_ff};
               cur_in   = rd_parent;
               state_in = ST_C_RD;
            end
         end

         ST_U_LINK: begin
            if (ra_ff == rb_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_root_in   = idx_to_elem(ra_ff);
               rsp_merged_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (rank_a_ff < rank_b_ff) begin
               wr_en         = 1'b1;
               wr_addr       = ra_ff;
               wr_data       = {1'b1, rank_a_ff, rb_ff};
               rsp_strobe_in = 1'b1;
               rsp_root_in   = idx_to_elem(rb_ff);
               rsp_merged_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = rb_ff;
               wr_data = {1'b1, rank_b_ff, ra_ff};
               if (rank_b_ff < rank_a_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_root_in   = idx_to_elem(ra_ff);
                  rsp_merged_in = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_U_RANK;
               end
            end
         end

         ST_U_RANK: begin
            // Equal ranks: the first root keeps its place and its rank rises, saturating at RANK_MAX.
            wr_en   = 1'b1;
            wr_addr = ra_ff;
            wr_data = {1'b1,
                       (rank_a_ff == RANK_MAX) ? rank_a_ff : rank_a_ff + RANK_W'(1),
                       ra_ff};
            rsp_strobe_in = 1'b1;
            rsp_root_in   = idx_to_elem(ra_ff);
            rsp_merged_in = 1'b1;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A finished find either answers or hands its root to the union step.
      if (fd_done) begin
         if (op_ff == OP_FIND) begin
            rsp_strobe_in = 1'b1;
            rsp_root_in   = idx_to_elem(fd_root);
            rsp_merged_in = 1'b0;
            state_in      = ST_IDLE;
         end else if (!phase_b_ff) begin
            ra_in      = fd_root;
            rank_a_in  = fd_rank;
            phase_b_in = 1'b1;
            cur_in     = idx_b_ff;
            target_in  = idx_b_ff;
            state_in   = ST_F_RD;
         end else begin
            rb_in     = fd_root;
            rank_b_in = fd_rank;
            state_in  = ST_U_LINK;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_b_ff      <= idx_b_in;
      cur_ff        <= cur_in;
      target_ff     <= target_in;
      root_ff       <= root_in;
      rank_root_ff  <= rank_root_in;
      phase_b_ff    <= phase_b_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      rank_a_ff     <= rank_a_in;
      rank_b_ff     <= rank_b_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_merged = rsp_merged_ff;

   // A response beat follows only a busy cycle or a request taken in the cycle before.
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy || start))
      else $error("response beat without a request");

   // Leaving busy after a request always comes with its response beat.
   a_done_responds: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(state_ff == ST_CLEAR)) |-> rsp_strobe)
      else $error("request finished without a response beat");

   // Only a union can report a merge.
   a_merge_union: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_merged) |-> (op_ff == OP_UNION))
      else $error("merge reported for a request other than union");

endmodule
